>>> hw/rtl/i2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 20;

    // Request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 6;
    localparam int TOTAL_W = 7;

    // Input tdata layout, lowest bit first.
    localparam int VALUE_BITS_W = 32;
    localparam int TD_VALUE_LSB = 0;
    localparam int TD_UPPER     = 32;
    localparam int TD_MINW_LSB  = 33;
    localparam int MINW_W       = 6;
    localparam int TD_PREC_LSB  = 39;
    localparam int PREC_W       = 7;
    localparam int TD_LEFT      = 46;
    localparam int TD_PLUS      = 47;
    localparam int TD_SPACE     = 48;
    localparam int TD_ZPAD      = 49;
    localparam int S_TDATA_W    = 56;

    // Input tuser layout, lowest bit first.
    localparam int TU_SIGNED    = 0;
    localparam int TU_BASE_LSB  = 1;
    localparam int BSEL_W       = 2;
    localparam int S_TUSER_W    = 3;

    localparam logic [BSEL_W-1:0] BSEL_OCT = 2'd0;
    localparam logic [BSEL_W-1:0] BSEL_DEC = 2'd1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [0:15][CHAR_W-1:0] HEX_UPPER = "0123456789ABCDEF";
    localparam logic [0:15][CHAR_W-1:0] HEX_LOWER = "0123456789abcdef";

    typedef enum logic [1:0] {
        BASE_OCT,
        BASE_DEC,
        BASE_HEX
    } base_t;

    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_MINUS,
        SIGN_PLUS,
        SIGN_SPACE
    } sign_t;

    typedef struct packed {
        sign_t             sign;
        base_t             base;
        logic              upper;
        logic [MINW_W-1:0] min_width;
        logic [CNT_W-1:0]  prec;
        logic              left;
        logic              zpad;
    } req_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_SIZE,
        BK_CALC,
        BK_EMIT
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] ch;
        begin
            ch = upper ? HEX_UPPER[d] : HEX_LOWER[d];
            return ch;
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/integer_to_ascii_formatter.sv
`default_nettype none
// Flow: a transferred request is written into the queue; the back pops it in BK_IDLE,
// passes through BK_CONV for the shift-and-add-3 conversion (decimal only), BK_SIZE and
// BK_CALC, and sends the field in BK_EMIT. Throughput: one character per cycle unless
// m_tready stalls the output; the output idles between fields while the back sizes the
// next request. The queue holds two requests while a field is sent.
// Reset (rst_n, asynchronous, active low) empties the queue and the output register.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer conversion request into a stream of ASCII characters in
// the manner of a printf integer conversion.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: value_bits[31:0], upper_case, min_width[5:0], precision[6:0],
    // left_justify, plus_sign, space_sign, zero_pad, then zero fill to 56 bits.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: is_signed, base_select[1:0].
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: out_char[7:0].
    output logic [CHAR_W-1:0]          m_tdata,
    // Carries last_char: high on the final character of a field.
    output logic                       m_tlast
);

    // The front resolves sign and magnitude in the cycle of the transfer and
    // writes the classified request into the queue, so a new request can be
    // taken while the back is still sending the previous field.
    q_status_t              q_status;
    logic                   push;
    logic [VALUE_WIDTH-1:0] push_mag;
    req_ctrl_t              push_ctrl;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] rd_mag;
    req_ctrl_t              rd_ctrl;

    i2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_mag  (push_mag),
        .push_ctrl (push_ctrl)
    );

    i2a_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_mag  (push_mag),
        .push_ctrl (push_ctrl),
        .pop       (pop),
        .q_status  (q_status),
        .rd_mag    (rd_mag),
        .rd_ctrl   (rd_ctrl)
    );

    // The back converts the magnitude to digits, sizes the padding and sends
    // one character per cycle, unless m_tready stalls it, through its output register.
    i2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_mag    (rd_mag),
        .q_ctrl   (rd_ctrl),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> hw/rtl/i2a_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_front
// Accepts a conversion request, resolves sign, magnitude, base and precision,
// and pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module i2a_front
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    input  wire q_status_t              q_status,
    output logic                        push,
    output logic [VALUE_WIDTH-1:0]      push_mag,
    output req_ctrl_t                   push_ctrl
);

    logic [VALUE_WIDTH-1:0] value;
    logic [PREC_W-1:0]      prec_raw;
    logic [BSEL_W-1:0]      bsel;
    logic                   is_signed;
    logic                   negative;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        value     = s_tdata[TD_VALUE_LSB +: VALUE_WIDTH];
        prec_raw  = s_tdata[TD_PREC_LSB +: PREC_W];
        bsel      = s_tuser[TU_BASE_LSB +: BSEL_W];
        is_signed = s_tuser[TU_SIGNED];
        negative  = is_signed && value[VALUE_WIDTH-1];

        push_mag = negative ? (~value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : value;

        push_ctrl.upper     = s_tdata[TD_UPPER];
        push_ctrl.min_width = s_tdata[TD_MINW_LSB +: MINW_W];
        push_ctrl.left      = s_tdata[TD_LEFT];
        push_ctrl.zpad      = s_tdata[TD_ZPAD];
        // A negative precision means none was given.
        push_ctrl.prec      = prec_raw[PREC_W-1] ? '0 : prec_raw[CNT_W-1:0];

        case (bsel)
            BSEL_OCT: push_ctrl.base = BASE_OCT;
            BSEL_DEC: push_ctrl.base = BASE_DEC;
            default:  push_ctrl.base = BASE_HEX;
        endcase

        if (negative)
            push_ctrl.sign = SIGN_MINUS;
        else if (is_signed && s_tdata[TD_PLUS])
            push_ctrl.sign = SIGN_PLUS;
        else if (is_signed && s_tdata[TD_SPACE])
            push_ctrl.sign = SIGN_SPACE;
        else
            push_ctrl.sign = SIGN_NONE;
    end

endmodule
`default_nettype wire

>>> hw/rtl/i2a_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module i2a_queue
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [VALUE_WIDTH-1:0] push_mag,
    input  wire req_ctrl_t              push_ctrl,
    input  wire logic                   pop,
    output q_status_t                   q_status,
    output logic [VALUE_WIDTH-1:0]      rd_mag,
    output req_ctrl_t                   rd_ctrl
);

    logic [VALUE_WIDTH-1:0] mag_mem_reg  [QUEUE_DEPTH];
    req_ctrl_t              ctrl_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        q_status.empty = (count_reg == '0);
        rd_mag         = mag_mem_reg[rd_ptr_reg];
        rd_ctrl        = ctrl_mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_mem_reg[wr_ptr_reg]  <= push_mag;
            ctrl_mem_reg[wr_ptr_reg] <= push_ctrl;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/i2a_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_back
// Turns one classified request into digits (shift-and-add-3 for decimal,
// bit slices for octal and hex), sizes the field and emits its characters.
// ----------------------------------------------------------------------------
module i2a_back
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire q_status_t              q_status,
    input  wire logic [VALUE_WIDTH-1:0] q_mag,
    input  wire req_ctrl_t              q_ctrl,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [CHAR_W-1:0]           m_tdata,
    output logic                        m_tlast
);

    localparam int EXT_W = 4 * MAX_DIGITS;
    localparam int CCW   = $clog2(VALUE_WIDTH + 1);
    localparam int DCW   = $clog2(MAX_DIGITS + 1);
    localparam int DIW   = $clog2(MAX_DIGITS);

    back_state_t            state_reg, state_next;
    req_ctrl_t              ctrl_reg, ctrl_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [3:0]             digits_reg [MAX_DIGITS];
    logic [3:0]             digits_next [MAX_DIGITS];
    logic [CCW-1:0]         conv_cnt_reg, conv_cnt_next;
    logic [DCW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic [CNT_W-1:0]       lead_reg, lead_next;
    logic [CNT_W-1:0]       zeros_reg, zeros_next;
    logic [CNT_W-1:0]       trail_reg, trail_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic [EXT_W-1:0]       ext_mag;
    logic [3:0]             load_digits [MAX_DIGITS];
    logic [3:0]             adj [MAX_DIGITS];
    logic [3:0]             dab_digits [MAX_DIGITS];
    logic [DCW-1:0]         place;
    logic [TOTAL_W-1:0]     prec_w, place_w, bigger;
    logic signed [7:0]      spaces_raw;
    logic [CNT_W-1:0]       spaces, zeros;
    logic                   has_sign;
    logic                   emit_go;
    logic [CHAR_W-1:0]      sign_char;
    logic [DIW-1:0]         dig_idx;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign emit_go  = (state_reg == BK_EMIT) && (!out_valid_reg || m_tready);

    // Digit sources: direct slices for octal and hex, one double-dabble step for decimal.
    always_comb
    begin
        ext_mag = {{(EXT_W-VALUE_WIDTH){1'b0}}, q_mag};
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (q_ctrl.base == BASE_OCT)
                load_digits[i] = {1'b0, ext_mag[3*i +: 3]};
            else
                load_digits[i] = ext_mag[4*i +: 4];
            adj[i] = (digits_reg[i] >= 4'd5) ? digits_reg[i] + 4'd3 : digits_reg[i];
        end
        dab_digits[0] = {adj[0][2:0], shift_reg[VALUE_WIDTH-1]};
        for (int i = 1; i < MAX_DIGITS; i++)
            dab_digits[i] = {adj[i][2:0], adj[i-1][3]};
    end

    // Field sizing from the digit count and the request.
    always_comb
    begin
        place = DCW'(1);
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            if (digits_reg[i] != 4'd0)
                place = DCW'(i + 1);
        end

        has_sign   = (ctrl_reg.sign != SIGN_NONE);
        prec_w     = {1'b0, ctrl_reg.prec};
        place_w    = TOTAL_W'(dig_cnt_reg);
        bigger     = (prec_w >= place_w) ? prec_w : place_w;
        spaces_raw = $signed({2'b00, ctrl_reg.min_width}) - $signed({1'b0, bigger})
                   - $signed({7'd0, has_sign});
        spaces     = spaces_raw[7] ? '0 : spaces_raw[CNT_W-1:0];
        zeros      = (prec_w > place_w) ? CNT_W'(prec_w - place_w) : '0;
        if (ctrl_reg.zpad)
        begin
            if (spaces > zeros)
                zeros = spaces;
            spaces = '0;
        end

        case (ctrl_reg.sign)
            SIGN_MINUS: sign_char = CH_MINUS;
            SIGN_PLUS:  sign_char = CH_PLUS;
            default:    sign_char = CH_SPACE;
        endcase
        dig_idx = DIW'(dig_cnt_reg - 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl_next      = ctrl_reg;
        shift_next     = shift_reg;
        digits_next    = digits_reg;
        conv_cnt_next  = conv_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        lead_next      = lead_reg;
        zeros_next     = zeros_reg;
        trail_next     = trail_reg;
        sign_pend_next = sign_pend_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop     = 1'b1;
                    ctrl_next = q_ctrl;
                    if (q_ctrl.base == BASE_DEC)
                    begin
                        shift_next    = q_mag;
                        conv_cnt_next = CCW'(VALUE_WIDTH);
                        for (int i = 0; i < MAX_DIGITS; i++)
                            digits_next[i] = 4'd0;
                        state_next = BK_CONV;
                    end
                    else
                    begin
                        digits_next = load_digits;
                        state_next  = BK_SIZE;
                    end
                end
            end
            BK_CONV:
            begin
                digits_next   = dab_digits;
                shift_next    = shift_reg << 1;
                conv_cnt_next = conv_cnt_reg - 1'b1;
                if (conv_cnt_reg == CCW'(1))
                    state_next = BK_SIZE;
            end
            BK_SIZE:
            begin
                dig_cnt_next = place;
                state_next   = BK_CALC;
            end
            BK_CALC:
            begin
                lead_next      = ctrl_reg.left ? '0 : spaces;
                trail_next     = ctrl_reg.left ? spaces : '0;
                zeros_next     = zeros;
                sign_pend_next = has_sign;
                total_next     = TOTAL_W'(spaces) + TOTAL_W'(zeros) + place_w
                               + TOTAL_W'(has_sign);
                state_next     = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (total_reg == TOTAL_W'(1));
                    total_next     = total_reg - 1'b1;
                    if (lead_reg != '0)
                    begin
                        out_char_next = CH_SPACE;
                        lead_next     = lead_reg - 1'b1;
                    end
                    else if (sign_pend_reg)
                    begin
                        out_char_next  = sign_char;
                        sign_pend_next = 1'b0;
                    end
                    else if (zeros_reg != '0)
                    begin
                        out_char_next = CH_ZERO;
                        zeros_next    = zeros_reg - 1'b1;
                    end
                    else if (dig_cnt_reg != '0)
                    begin
                        out_char_next = digit_char(digits_reg[dig_idx], ctrl_reg.upper);
                        dig_cnt_next  = dig_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        out_char_next = CH_SPACE;
                        trail_next    = trail_reg - 1'b1;
                    end
                    if (total_reg == TOTAL_W'(1))
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            conv_cnt_reg  <= '0;
            dig_cnt_reg   <= '0;
            lead_reg      <= '0;
            zeros_reg     <= '0;
            trail_reg     <= '0;
            sign_pend_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            lead_reg      <= lead_next;
            zeros_reg     <= zeros_next;
            trail_reg     <= trail_next;
            sign_pend_reg <= sign_pend_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_next;
        shift_reg    <= shift_next;
        digits_reg   <= digits_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // While characters are being sent there is always at least one left.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT) |-> (total_reg != '0))
        else $error("emit state entered with no characters left");

    // The final character of a field carries the last mark and frees the back.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && total_reg == TOTAL_W'(1)) |=> (out_last_reg && state_reg == BK_IDLE))
        else $error("final character not marked last");

    // The digit count used for sizing is between one and the digit limit.
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CALC) |-> (dig_cnt_reg != '0 && dig_cnt_reg <= DCW'(MAX_DIGITS)))
        else $error("digit count out of range");

endmodule
`default_nettype wire
